[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/att_pkg.sv]
// ----------------------------------------------------------------------------
// att_pkg
// Shared constants and helpers for the tilt angle pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package att_pkg;
    localparam int ATAN_LEN   = 24;
    localparam int MAG_W      = 26;  // floor(sqrt(2^31 * 2^16)) < 2^24, margin
    localparam int SUM_W      = 48;  // (a^2+b^2) << 16
    localparam int CW         = 44;  // CORDIC x/y width
    localparam int ZW         = 24;
    localparam logic [13:0] FLAT_LIMIT_RST = 14'd200;
    localparam logic signed [14:0] ANGLE_MAX = 15'sd9000;

    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        logic signed [ZW-1:0] t;
        begin
            unique case (i)
                0: t = 24'sd1152000;  1: t = 24'sd680065;  2: t = 24'sd359328;
                3: t = 24'sd182400;   4: t = 24'sd91554;   5: t = 24'sd45822;
                6: t = 24'sd22916;    7: t = 24'sd11459;   8: t = 24'sd5730;
                9: t = 24'sd2865;    10: t = 24'sd1432;   11: t = 24'sd716;
                12: t = 24'sd358;    13: t = 24'sd179;    14: t = 24'sd90;
                15: t = 24'sd45;     16: t = 24'sd22;     17: t = 24'sd11;
                18: t = 24'sd6;      19: t = 24'sd3;      20: t = 24'sd1;
                21: t = 24'sd1;
                default: t = '0;
            endcase
            return t;
        end
    endfunction
endpackage
`default_nettype wire

[rtl/accel_tilt_angles.sv]
// Throughput: one sample per cycle; busy is tied low, one transaction may enter
// every cycle. Set by the pipelined square root (one result bit per stage) and
// the unrolled CORDIC (one micro-rotation per stage).
// Reset: asynchronous, active low; clears all valid bits and sets flat_limit to 200.
// The receiver cannot stall; a result is shown for one cycle with done high.
// ----------------------------------------------------------------------------
// accel_tilt_angles
// Roll and pitch of a three-axis accelerometer sample in 0.01 degree.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module accel_tilt_angles #(
    parameter int ANGLE_ITERATIONS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [15:0] accel_x,
    input  wire logic signed [15:0] accel_y,
    input  wire logic signed [15:0] accel_z,
    input  wire logic               cfg_we,
    input  wire logic [13:0]        cfg_wdata,
    output logic                    done,
    output logic signed [14:0]      pitch_angle,
    output logic signed [14:0]      roll_angle,
    output logic                    is_flat
);
    localparam int SW   = att_pkg::SUM_W;
    localparam int MW   = att_pkg::MAG_W;
    localparam int CW   = att_pkg::CW;
    localparam int ZW   = att_pkg::ZW;
    localparam int NIT  = (ANGLE_ITERATIONS < att_pkg::ATAN_LEN) ?
                          ANGLE_ITERATIONS : att_pkg::ATAN_LEN;
    localparam int SQS  = SW / 2;   // square root stages, one result bit each
    localparam int NL   = 2;        // two lanes: 0 = roll, 1 = pitch

    assign busy = 1'b0;

    // flat_limit register
    logic [13:0] flat_limit_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flat_limit_reg <= att_pkg::FLAT_LIMIT_RST;
        else if (cfg_we)
            flat_limit_reg <= cfg_wdata;
    end

    // ------------------------------------------------------------------
    // Stage 1: squares. Stage 2: sums. Numerators ride along (17 bits).
    // ------------------------------------------------------------------
    logic               v1_reg, v2_reg;
    logic [31:0]        sqx_reg, sqy_reg, sqz_reg;
    logic signed [16:0] n1_reg [NL];
    logic signed [16:0] n2_reg [NL];
    logic [SW-1:0]      sum2_reg [NL];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sqx_reg   <= 32'(accel_x * accel_x);
        sqy_reg   <= 32'(accel_y * accel_y);
        sqz_reg   <= 32'(accel_z * accel_z);
        n1_reg[0] <= 17'(accel_x);
        n1_reg[1] <= -17'(accel_y);
        n2_reg    <= n1_reg;
        // radicand is the sum with 16 fraction bits, below 2^48
        sum2_reg[0] <= SW'({33'(sqy_reg) + 33'(sqz_reg), 16'b0});
        sum2_reg[1] <= SW'({33'(sqx_reg) + 33'(sqz_reg), 16'b0});
    end

    // ------------------------------------------------------------------
    // Square root: restoring, one result bit per stage, both lanes.
    // ------------------------------------------------------------------
    logic               sv_reg  [SQS+1];
    logic [SW-1:0]      rem_reg [SQS+1][NL];
    logic [SW-1:0]      rad_reg [SQS+1][NL];
    logic [MW-1:0]      root_reg[SQS+1][NL];
    logic signed [16:0] sn_reg  [SQS+1][NL];

    always_comb
    begin
        sv_reg[0]   = v2_reg;
        for (int l = 0; l < NL; l++)
        begin
            rem_reg[0][l]  = '0;
            rad_reg[0][l]  = sum2_reg[l];
            root_reg[0][l] = '0;
            sn_reg[0][l]   = n2_reg[l];
        end
    end

    for (genvar s = 0; s < SQS; s++)
    begin : g_sqrt
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sv_reg[s+1] <= 1'b0;
            else
                sv_reg[s+1] <= sv_reg[s];
        end
        for (genvar l = 0; l < NL; l++)
        begin : g_lane
            logic [SW+1:0] rem_sh;
            logic [SW+1:0] trial;
            assign rem_sh = {rem_reg[s][l], rad_reg[s][l][SW-1 -: 2]};
            assign trial  = {(SW-MW)'(0), root_reg[s][l], 2'b01};
            always_ff @(posedge clk)
            begin
                rad_reg[s+1][l] <= rad_reg[s][l] << 2;
                sn_reg[s+1][l]  <= sn_reg[s][l];
                if (rem_sh >= trial)
                begin
                    rem_reg[s+1][l]  <= SW'(rem_sh - trial);
                    root_reg[s+1][l] <= {root_reg[s][l][MW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s+1][l]  <= SW'(rem_sh);
                    root_reg[s+1][l] <= {root_reg[s][l][MW-2:0], 1'b0};
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // CORDIC vectoring, one micro-rotation per stage.
    // X = M<<8, Y = num<<16, 16 fraction bits.
    // ------------------------------------------------------------------
    logic                 cv_reg [NIT+1];
    logic signed [CW-1:0] cx_reg [NIT+1][NL];
    logic signed [CW-1:0] cy_reg [NIT+1][NL];
    logic signed [ZW-1:0] cz_reg [NIT+1][NL];
    logic                 nz_reg [NIT+1][NL];  // numerator zero
    logic                 mz_reg [NIT+1][NL];  // magnitude zero
    logic                 ns_reg [NIT+1][NL];  // numerator sign

    always_comb
    begin
        cv_reg[0] = sv_reg[SQS];
        for (int l = 0; l < NL; l++)
        begin
            cx_reg[0][l] = {CW'(root_reg[SQS][l]) << 8};
            cy_reg[0][l] = CW'(sn_reg[SQS][l]) <<< 16;
            cz_reg[0][l] = '0;
            nz_reg[0][l] = (sn_reg[SQS][l] == '0);
            mz_reg[0][l] = (root_reg[SQS][l] == '0);
            ns_reg[0][l] = sn_reg[SQS][l][16];
        end
    end

    for (genvar i = 0; i < NIT; i++)
    begin : g_cordic
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cv_reg[i+1] <= 1'b0;
            else
                cv_reg[i+1] <= cv_reg[i];
        end
        for (genvar l = 0; l < NL; l++)
        begin : g_lane
            always_ff @(posedge clk)
            begin
                nz_reg[i+1][l] <= nz_reg[i][l];
                mz_reg[i+1][l] <= mz_reg[i][l];
                ns_reg[i+1][l] <= ns_reg[i][l];
                if (!cy_reg[i][l][CW-1])
                begin
                    cx_reg[i+1][l] <= cx_reg[i][l] + (cy_reg[i][l] >>> i);
                    cy_reg[i+1][l] <= cy_reg[i][l] - (cx_reg[i][l] >>> i);
                    cz_reg[i+1][l] <= cz_reg[i][l] + att_pkg::atan_entry(i);
                end
                else
                begin
                    cx_reg[i+1][l] <= cx_reg[i][l] - (cy_reg[i][l] >>> i);
                    cy_reg[i+1][l] <= cy_reg[i][l] + (cx_reg[i][l] >>> i);
                    cz_reg[i+1][l] <= cz_reg[i][l] - att_pkg::atan_entry(i);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Round, saturate, special cases; then flat compare and output.
    // ------------------------------------------------------------------
    logic                 fv_reg;
    logic signed [14:0]   ang_reg [NL];
    logic signed [ZW-1:0] zr      [NL];
    logic signed [15:0]   ang_next[NL];

    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            zr[l] = (cz_reg[NIT][l] + ZW'(128)) >>> 8;
            priority if (nz_reg[NIT][l])
                ang_next[l] = '0;
            else if (mz_reg[NIT][l])
                ang_next[l] = ns_reg[NIT][l] ? -16'sd9000 : 16'sd9000;
            else if (zr[l] > ZW'(9000))
                ang_next[l] = 16'sd9000;
            else if (zr[l] < -ZW'(9000))
                ang_next[l] = -16'sd9000;
            else
                ang_next[l] = 16'(zr[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
            done   <= 1'b0;
        end
        else
        begin
            fv_reg <= cv_reg[NIT];
            done   <= fv_reg;
        end
    end

    logic signed [15:0] lim_s;
    assign lim_s = 16'(flat_limit_reg);

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < NL; l++)
            ang_reg[l] <= 15'(ang_next[l]);
        roll_angle  <= ang_reg[0];
        pitch_angle <= ang_reg[1];
        is_flat     <= (16'(ang_reg[0]) > -lim_s) && (16'(ang_reg[0]) < lim_s)
                    && (16'(ang_reg[1]) > -lim_s) && (16'(ang_reg[1]) < lim_s);
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_CLK(a_busy_low, clk, rst_n, !busy)
    `ASSERT_NEXT(a_done_follows, clk, rst_n, fv_reg, done)
    `ASSERT_NEXT(a_angle_range, clk, rst_n, fv_reg,
        roll_angle <= att_pkg::ANGLE_MAX && roll_angle >= -att_pkg::ANGLE_MAX)
    `ASSERT_NEXT(a_zero_lim, clk, rst_n, fv_reg && flat_limit_reg == '0 && !cfg_we, !is_flat)

endmodule
`default_nettype wire
